// File: sv/clf_pkg.sv
// clf_pkg: shared types and constants of the crlf line framer
// used by every module of the framer; depends on nothing

package clf_pkg;

    localparam int STORE_DEPTH    = 16;
    localparam int CAP_W          = 8;
    localparam int LEN_W          = 8;
    localparam int QUEUE_DEPTH    = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 8'd64;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    typedef enum logic [2:0] {
        ST_WAITING   = 3'd0,
        ST_READY     = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_TOO_SMALL = 3'd3,
        ST_INVALID   = 3'd4
    } t_status;

    // one command from the front to the back
    typedef struct packed {
        logic             is_frame;
        t_status          status;
        logic [LEN_W-1:0] len;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EMIT
    } t_back_state;

endpackage

// File: sv/crlf_line_framer_core.sv
// crlf_line_framer_core: top level of the crlf line framer
// depends on clf_pkg, clf_front, clf_cmd_queue and clf_back
//
// channel | valid       | stall       | payload
// in      | i_in_valid  | o_in_stall  | i_in_byte
// out     | o_out_valid | i_out_stall | o_status, o_frame_byte, o_byte_valid, o_frame_last
// cfg     | i_cfg_we    | none        | i_cfg_wdata
//
// the front takes one byte per cycle while the command queue has room and no frame awaits readout
// a status result is registered into the back's output register when the back pops its command from the queue head
// each frame byte passes through the back as a store read, then the output register
// the front holds off new bytes from a frame end until its last byte is read out
// reset is synchronous; capacity returns to 64, store contents stay unknown

module crlf_line_framer_core #(
    parameter int StoreDepth = clf_pkg::STORE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_in_byte,
    input  logic                      i_cfg_we,
    input  logic [clf_pkg::CAP_W-1:0] i_cfg_wdata,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [2:0]                o_status,
    output logic [7:0]                o_frame_byte,
    output logic                      o_byte_valid,
    output logic                      o_frame_last
);
    import clf_pkg::*;

    localparam int AddrW = $clog2(StoreDepth);

    logic             push, pop, q_empty, q_full, frame_done;
    t_cmd             push_cmd, head;
    logic [AddrW-1:0] rd_addr;
    logic [7:0]       rd_data;

    clf_front #(.StoreDepth(StoreDepth)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_push       (push),
        .o_push_cmd   (push_cmd),
        .i_q_full     (q_full),
        .i_frame_done (frame_done),
        .i_rd_addr    (rd_addr),
        .o_rd_data    (rd_data)
    );

    clf_cmd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_empty    (q_empty),
        .o_full     (q_full)
    );

    clf_back #(.StoreDepth(StoreDepth)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_frame_done (frame_done),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_frame_byte (o_frame_byte),
        .o_byte_valid (o_byte_valid),
        .o_frame_last (o_frame_last)
    );

`ifndef NO_ASSERTIONS
    a_byte_is_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_valid |-> o_status == ST_READY)
        else $error("frame byte without ready status");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_frame_last && o_frame_byte == 8'd0)
        else $error("status-only result not marked last");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> o_in_stall)
        else $error("input taken while command queue full");

    a_frame_cmd_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && push_cmd.is_frame |=> o_in_stall)
        else $error("input not held off during frame readout");
`endif

endmodule

// File: sv/clf_cmd_queue.sv
// clf_cmd_queue: short command queue between front and back of the framer
// depends on clf_pkg

module clf_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  clf_pkg::t_cmd i_push_cmd,
    input  logic          i_pop,
    output clf_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);
    import clf_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CntW'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// File: sv/clf_front.sv
// clf_front: byte intake, classification, capacity register and frame store
// depends on clf_pkg

module clf_front #(
    parameter int StoreDepth = clf_pkg::STORE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_cfg_we,
    input  logic [clf_pkg::CAP_W-1:0]     i_cfg_wdata,
    output logic                          o_push,
    output clf_pkg::t_cmd                 o_push_cmd,
    input  logic                          i_q_full,
    input  logic                          i_frame_done,
    input  logic [$clog2(StoreDepth)-1:0] i_rd_addr,
    output logic [7:0]                    o_rd_data
);
    import clf_pkg::*;

    localparam int CntW = $clog2(StoreDepth);
    localparam int CmpW = LEN_W + 1;

    logic [7:0]       r_store [StoreDepth];
    logic [7:0]       r_rd_data;
    logic [CAP_W-1:0] r_out_capacity;
    logic [CntW-1:0]  r_fill, n_fill;
    logic             r_discard, n_discard;
    logic             r_pend, n_pend;
    logic             accept, is_delim, wr_en, fits, full;
    logic [CmpW-1:0]  need;

    assign o_in_stall = i_q_full | r_pend;
    assign accept     = i_in_valid & ~o_in_stall;
    assign is_delim   = (i_in_byte == CHAR_CR) || (i_in_byte == CHAR_LF);
    assign need       = CmpW'(r_fill) + CmpW'(1);
    assign fits       = need <= CmpW'(r_out_capacity);
    assign full       = r_fill >= CntW'(StoreDepth - 1);
    assign o_rd_data  = r_rd_data;

    always_comb begin
        n_fill     = r_fill;
        n_discard  = r_discard;
        n_pend     = r_pend & ~i_frame_done;
        wr_en      = 1'b0;
        o_push     = accept;
        o_push_cmd = '{is_frame: 1'b0, status: ST_WAITING, len: '0};
        if (accept) begin
            if (r_out_capacity == '0) begin
                o_push_cmd.status = ST_INVALID;
            end else if (r_discard) begin
                if (is_delim) begin
                    n_discard = 1'b0;
                end
            end else if (is_delim) begin
                if (r_fill != '0) begin
                    n_fill = '0;
                    if (fits) begin
                        o_push_cmd = '{is_frame: 1'b1, status: ST_READY, len: LEN_W'(r_fill)};
                        n_pend     = 1'b1;
                    end else begin
                        o_push_cmd.status = ST_TOO_SMALL;
                    end
                end
            end else if (full) begin
                n_fill            = '0;
                n_discard         = 1'b1;
                o_push_cmd.status = ST_OVERFLOW;
            end else begin
                wr_en  = 1'b1;
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_capacity <= CAP_RESET;
            r_fill         <= '0;
            r_discard      <= 1'b0;
            r_pend         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_out_capacity <= i_cfg_wdata;
            end
            r_fill    <= n_fill;
            r_discard <= n_discard;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_fill] <= i_in_byte;
        end
        r_rd_data <= r_store[i_rd_addr];
    end

endmodule

// File: sv/clf_back.sv
// clf_back: result sequencer, expands commands into result items
// depends on clf_pkg; reads the frame store held in clf_front

module clf_back #(
    parameter int StoreDepth = clf_pkg::STORE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  clf_pkg::t_cmd                 i_head,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic [$clog2(StoreDepth)-1:0] o_rd_addr,
    input  logic [7:0]                    i_rd_data,
    output logic                          o_frame_done,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_status,
    output logic [7:0]                    o_frame_byte,
    output logic                          o_byte_valid,
    output logic                          o_frame_last
);
    import clf_pkg::*;

    localparam int CntW = $clog2(StoreDepth);

    t_back_state     r_state, n_state;
    logic [CntW-1:0] r_idx, n_idx;
    logic [CntW-1:0] r_len, n_len;
    logic            r_out_valid, n_out_valid;
    t_status         r_status, n_status;
    logic [7:0]      r_byte, n_byte;
    logic            r_bvalid, n_bvalid;
    logic            r_last, n_last;
    logic            slot_free, is_end;

    assign slot_free    = ~r_out_valid | ~i_out_stall;
    assign is_end       = (r_idx + 1'b1) == r_len;
    assign o_rd_addr    = r_idx;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_frame_byte = r_byte;
    assign o_byte_valid = r_bvalid;
    assign o_frame_last = r_last;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_len        = r_len;
        n_out_valid  = r_out_valid & i_out_stall;
        n_status     = r_status;
        n_byte       = r_byte;
        n_bvalid     = r_bvalid;
        n_last       = r_last;
        o_pop        = 1'b0;
        o_frame_done = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty && slot_free) begin
                    o_pop = 1'b1;
                    if (i_head.is_frame) begin
                        n_idx   = '0;
                        n_len   = CntW'(i_head.len);
                        n_state = BK_READ;
                    end else begin
                        n_out_valid = 1'b1;
                        n_status    = i_head.status;
                        n_byte      = '0;
                        n_bvalid    = 1'b0;
                        n_last      = 1'b1;
                    end
                end
            end
            BK_READ: begin
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_READY;
                    n_byte      = i_rd_data;
                    n_bvalid    = 1'b1;
                    n_last      = is_end;
                    if (is_end) begin
                        o_frame_done = 1'b1;
                        n_state      = BK_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = BK_READ;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_idx       <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_byte   <= n_byte;
        r_bvalid <= n_bvalid;
        r_last   <= n_last;
    end

endmodule
